@@ rtl/hq2x_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hq2x_pkg: shared types, constants and functions of the 2x window upscaler
// Holds the luma/chroma conversion, the difference test, the pattern
// rotation, the 256-entry rule table and the per-corner blend.
// ----------------------------------------------------------------------------
package hq2x_pkg;

  typedef logic [14:0] pixel_t;
  typedef logic [31:0] yuv_t;
  typedef logic [7:0]  pattern_t;
  typedef logic [4:0]  rule_t;

  localparam yuv_t YUV_OFFSET  = (32'h440 << 21) + (32'h207 << 11) + 32'h407;
  localparam yuv_t ALIKE_MASK  = (32'h380 << 21) + (32'h1f0 << 11) + 32'h3f0;

  // Blend rule codes held in the rule table.
  localparam rule_t RULE_PASS        = 5'd0;
  localparam rule_t RULE_EA_31       = 5'd1;
  localparam rule_t RULE_ED_31       = 5'd2;
  localparam rule_t RULE_EB_31       = 5'd3;
  localparam rule_t RULE_EDB_211     = 5'd4;
  localparam rule_t RULE_EAB_211     = 5'd5;
  localparam rule_t RULE_EAD_211     = 5'd6;
  localparam rule_t RULE_EBD_521     = 5'd7;
  localparam rule_t RULE_EDB_521     = 5'd8;
  localparam rule_t RULE_EDB_611     = 5'd9;
  localparam rule_t RULE_EDB_233     = 5'd10;
  localparam rule_t RULE_EDB_1411    = 5'd11;
  localparam rule_t RULE_BD_211      = 5'd12;
  localparam rule_t RULE_BD_233      = 5'd13;
  localparam rule_t RULE_BD_1411     = 5'd14;
  localparam rule_t RULE_BD_211_A    = 5'd15;
  localparam rule_t RULE_BD_611_A    = 5'd16;
  localparam rule_t RULE_BD_233_A    = 5'd17;
  localparam rule_t RULE_BF_521_D    = 5'd18;
  localparam rule_t RULE_DH_521_B    = 5'd19;

  localparam rule_t RULE_ROM [256] = '{
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd15, 5'd12, 5'd5, 5'd3, 5'd17, 5'd13,
    5'd4, 5'd4, 5'd6, 5'd18, 5'd4, 5'd4, 5'd6, 5'd18,
    5'd5, 5'd3, 5'd12, 5'd12, 5'd5, 5'd3, 5'd1, 5'd12,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd17, 5'd13, 5'd5, 5'd3, 5'd16, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd18, 5'd4, 5'd4, 5'd6, 5'd18,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd3, 5'd1, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd19, 5'd12, 5'd12, 5'd5, 5'd19, 5'd16, 5'd12,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd3, 5'd16, 5'd12,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd19, 5'd1, 5'd12, 5'd5, 5'd19, 5'd1, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd18,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd19, 5'd1, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd15, 5'd12, 5'd5, 5'd3, 5'd17, 5'd13,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd3, 5'd16, 5'd12,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd17, 5'd13, 5'd5, 5'd3, 5'd16, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd16, 5'd13, 5'd5, 5'd3, 5'd1, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd3, 5'd16, 5'd13,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd3, 5'd1, 5'd12,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd16, 5'd12, 5'd5, 5'd3, 5'd1, 5'd14,
    5'd4, 5'd4, 5'd6, 5'd2, 5'd4, 5'd4, 5'd6, 5'd2,
    5'd5, 5'd3, 5'd1, 5'd12, 5'd5, 5'd3, 5'd1, 5'd14
  };

  // Widen a 5-bit channel to 8 bits by repeating its top bits.
  function automatic logic [7:0] expand5(logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // Packed luma/chroma word. Divisions by 384 and 56 are a shift followed
  // by a reciprocal multiply for /3 and /7, exact over the value range.
  function automatic yuv_t luma_chroma(pixel_t px);
    logic [7:0]  r, g, b;
    logic [9:0]  sum;
    logic [16:0] y_num;
    logic [18:0] y_scaled;
    logic [9:0]  u_base;
    logic [13:0] u_num;
    logic [23:0] u_scaled;
    logic [10:0] v_base;
    logic [12:0] v_num;
    logic [7:0]  yy, uu, vv;
    r        = expand5(px[4:0]);
    g        = expand5(px[9:5]);
    b        = expand5(px[14:10]);
    sum      = 10'(r) + 10'(g) + 10'(b);
    y_num    = 17'(sum) * 17'd127;
    y_scaled = 19'(y_num[16:7]) * 19'd683;
    yy       = y_scaled[18:11];
    u_base   = 10'(r) + 10'd512 - 10'(b);
    u_num    = 14'(u_base) * 14'd15;
    u_scaled = 24'(u_num[13:3]) * 24'd9363;
    uu       = u_scaled[23:16];
    v_base   = {2'b00, g, 1'b0} + 11'd1024 - 11'(r) - 11'(b);
    v_num    = 13'(v_base) * 13'd5;
    vv       = v_num[12:5];
    return {3'b000, yy, 2'b00, uu, 3'b000, vv};
  endfunction

  // Two pixels are alike when no masked field of their offset difference
  // is set.
  function automatic logic alike(yuv_t p, yuv_t q);
    return ((p - q + YUV_OFFSET) & ALIKE_MASK) == '0;
  endfunction

  // Rotate the neighbor pattern by a quarter turn, counterclockwise.
  function automatic pattern_t quarter_turn(pattern_t m);
    return {m[5], m[3], m[0], m[6], m[1], m[7], m[4], m[2]};
  endfunction

  function automatic logic [4:0] mix_ch(logic [3:0] we, logic [3:0] wp, logic [3:0] wq,
                                        logic [2:0] sh, logic [4:0] ce, logic [4:0] cp,
                                        logic [4:0] cq);
    logic [8:0] acc;
    acc = 9'(we) * 9'(ce) + 9'(wp) * 9'(cp) + 9'(wq) * 9'(cq);
    return 5'(acc >> sh);
  endfunction

  // One output corner: e is the center, a the diagonal neighbor, b and d
  // the edge neighbors next to the corner, f and h the far edge pixels.
  function automatic pixel_t corner_px(rule_t code, pixel_t e, pixel_t a, pixel_t b,
                                       pixel_t d, logic bd, logic bf, logic dh);
    logic [3:0] we, wp, wq;
    logic [2:0] sh;
    pixel_t     p, q;
    logic       pass;
    we   = 4'd3;
    wp   = 4'd1;
    wq   = 4'd0;
    sh   = 3'd2;
    p    = a;
    q    = e;
    pass = 1'b0;
    case (code)
      RULE_EA_31: begin
        p = a;
      end
      RULE_ED_31: begin
        p = d;
      end
      RULE_EB_31: begin
        p = b;
      end
      RULE_EDB_211: begin
        we = 4'd2; p = d; q = b; wq = 4'd1;
      end
      RULE_EAB_211: begin
        we = 4'd2; p = a; q = b; wq = 4'd1;
      end
      RULE_EAD_211: begin
        we = 4'd2; p = a; q = d; wq = 4'd1;
      end
      RULE_EBD_521: begin
        we = 4'd5; wp = 4'd2; wq = 4'd1; sh = 3'd3; p = b; q = d;
      end
      RULE_EDB_521: begin
        we = 4'd5; wp = 4'd2; wq = 4'd1; sh = 3'd3; p = d; q = b;
      end
      RULE_EDB_611: begin
        we = 4'd6; wq = 4'd1; sh = 3'd3; p = d; q = b;
      end
      RULE_EDB_233: begin
        we = 4'd2; wp = 4'd3; wq = 4'd3; sh = 3'd3; p = d; q = b;
      end
      RULE_EDB_1411: begin
        we = 4'd14; wq = 4'd1; sh = 3'd4; p = d; q = b;
      end
      RULE_BD_211: begin
        we = 4'd2; wq = 4'd1; p = d; q = b; pass = !bd;
      end
      RULE_BD_233: begin
        we = 4'd2; wp = 4'd3; wq = 4'd3; sh = 3'd3; p = d; q = b; pass = !bd;
      end
      RULE_BD_1411: begin
        we = 4'd14; wq = 4'd1; sh = 3'd4; p = d; q = b; pass = !bd;
      end
      RULE_BD_211_A: begin
        if (bd) begin
          we = 4'd2; wq = 4'd1; p = d; q = b;
        end
      end
      RULE_BD_611_A: begin
        if (bd) begin
          we = 4'd6; wq = 4'd1; sh = 3'd3; p = d; q = b;
        end
      end
      RULE_BD_233_A: begin
        if (bd) begin
          we = 4'd2; wp = 4'd3; wq = 4'd3; sh = 3'd3; p = d; q = b;
        end
      end
      RULE_BF_521_D: begin
        if (bf) begin
          we = 4'd5; wp = 4'd2; wq = 4'd1; sh = 3'd3; p = b; q = d;
        end else begin
          p = d;
        end
      end
      RULE_DH_521_B: begin
        if (dh) begin
          we = 4'd5; wp = 4'd2; wq = 4'd1; sh = 3'd3; p = d; q = b;
        end else begin
          p = b;
        end
      end
      default: begin
        pass = 1'b1;
      end
    endcase
    if (pass) begin
      return e;
    end
    return {mix_ch(we, wp, wq, sh, e[14:10], p[14:10], q[14:10]),
            mix_ch(we, wp, wq, sh, e[9:5], p[9:5], q[9:5]),
            mix_ch(we, wp, wq, sh, e[4:0], p[4:0], q[4:0])};
  endfunction

endpackage
`default_nettype wire

@@ rtl/hq2x_window_upscale_kernel_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hq2x_window_upscale_kernel_core: 2x pixel-art upscaler kernel
// A 3x3 window of BGR555 pixels goes in; the 2x2 block replacing the center
// comes out, built from neighbor similarity and a rule table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel is a command port. A window transfer takes place at
//   each rising edge where start is high and busy is low. busy is always
//   low, so a new window may be presented in every cycle.
//   The result channel has no back-pressure: done is high for exactly one
//   cycle together with the four output pixels, and the receiver must take
//   the transfer in that cycle.
//   Pipeline: the window is captured at the accepting edge together with
//   the luma/chroma word of each of its nine pixels. The result register
//   is loaded from that stage, and done is registered from its valid flag.
//   Throughput: one window per cycle. The rate is set by the two register
//   stages, each of which takes a new window every cycle; the second stage
//   holds the pattern build, the rule table lookup and the blend.
//   Reset (rst, synchronous) clears both stage valid flags, so no result
//   transfer is produced from stale data. There is no state that links one
//   window to the next.
// ----------------------------------------------------------------------------
module hq2x_window_upscale_kernel_core (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        start,
  output       logic        busy,
  input  wire  logic [14:0] up_left,
  input  wire  logic [14:0] up,
  input  wire  logic [14:0] up_right,
  input  wire  logic [14:0] left,
  input  wire  logic [14:0] center,
  input  wire  logic [14:0] right,
  input  wire  logic [14:0] down_left,
  input  wire  logic [14:0] down,
  input  wire  logic [14:0] down_right,
  output       logic        done,
  output       logic [14:0] top_left,
  output       logic [14:0] top_right,
  output       logic [14:0] bottom_left,
  output       logic [14:0] bottom_right
);

  // Window slots: 0 up_left, 1 up, 2 up_right, 3 left, 4 center, 5 right,
  // 6 down_left, 7 down, 8 down_right.
  hq2x_pkg::pixel_t px [9];
  hq2x_pkg::yuv_t   yuv [9];
  logic             win_valid;

  hq2x_pkg::pixel_t px_next [9];

  hq2x_pkg::pattern_t pat_tl, pat_tr, pat_br, pat_bl;
  hq2x_pkg::pixel_t   tl_next, tr_next, br_next, bl_next;

  // The block never holds off a transfer.
  assign busy = 1'b0;

  assign px_next[0] = up_left;
  assign px_next[1] = up;
  assign px_next[2] = up_right;
  assign px_next[3] = left;
  assign px_next[4] = center;
  assign px_next[5] = right;
  assign px_next[6] = down_left;
  assign px_next[7] = down;
  assign px_next[8] = down_right;

  // First stage: capture the window and convert every pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else begin
      win_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      for (int k = 0; k < 9; k++) begin
        px[k]  <= px_next[k];
        yuv[k] <= hq2x_pkg::luma_chroma(px_next[k]);
      end
    end
  end

  // Second stage: a pattern bit is set for every neighbor that differs
  // from the center. The pattern is rotated for each following corner so
  // the same rule table serves all four.
  always_comb begin
    pat_tl = {!hq2x_pkg::alike(yuv[4], yuv[8]), !hq2x_pkg::alike(yuv[4], yuv[7]),
              !hq2x_pkg::alike(yuv[4], yuv[6]), !hq2x_pkg::alike(yuv[4], yuv[5]),
              !hq2x_pkg::alike(yuv[4], yuv[3]), !hq2x_pkg::alike(yuv[4], yuv[2]),
              !hq2x_pkg::alike(yuv[4], yuv[1]), !hq2x_pkg::alike(yuv[4], yuv[0])};
    pat_tr = hq2x_pkg::quarter_turn(pat_tl);
    pat_br = hq2x_pkg::quarter_turn(pat_tr);
    pat_bl = hq2x_pkg::quarter_turn(pat_br);
  end

  // Each corner sees the neighbors turned with it: the diagonal one, the
  // pair of edge ones next to the corner, and the far edge pixels used by the
  // conditional rules.
  always_comb begin
    tl_next = hq2x_pkg::corner_px(hq2x_pkg::RULE_ROM[pat_tl], px[4], px[0], px[1], px[3],
                                  hq2x_pkg::alike(yuv[1], yuv[3]),
                                  hq2x_pkg::alike(yuv[1], yuv[5]),
                                  hq2x_pkg::alike(yuv[3], yuv[7]));
    tr_next = hq2x_pkg::corner_px(hq2x_pkg::RULE_ROM[pat_tr], px[4], px[2], px[5], px[1],
                                  hq2x_pkg::alike(yuv[5], yuv[1]),
                                  hq2x_pkg::alike(yuv[5], yuv[7]),
                                  hq2x_pkg::alike(yuv[1], yuv[3]));
    br_next = hq2x_pkg::corner_px(hq2x_pkg::RULE_ROM[pat_br], px[4], px[8], px[7], px[5],
                                  hq2x_pkg::alike(yuv[7], yuv[5]),
                                  hq2x_pkg::alike(yuv[7], yuv[3]),
                                  hq2x_pkg::alike(yuv[5], yuv[1]));
    bl_next = hq2x_pkg::corner_px(hq2x_pkg::RULE_ROM[pat_bl], px[4], px[6], px[3], px[7],
                                  hq2x_pkg::alike(yuv[3], yuv[7]),
                                  hq2x_pkg::alike(yuv[3], yuv[1]),
                                  hq2x_pkg::alike(yuv[7], yuv[5]));
  end

  // Result register: one transfer per captured window, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid) begin
      top_left     <= tl_next;
      top_right    <= tr_next;
      bottom_left  <= bl_next;
      bottom_right <= br_next;
    end
  end

endmodule
`default_nettype wire
